// ----- sv/lsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the lidar scan point plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

    localparam int unsigned LSP_HISTORY_DEPTH = 1024;
    localparam int unsigned LSP_TRIG_BITS     = 16;
    localparam int unsigned LSP_QUEUE_DEPTH   = 2;

    // angles in 1/64 degree
    localparam int unsigned ANG_FULL    = 23040;
    localparam int unsigned ANG_QUARTER = 5760;
    // pi/11520 as Q40
    localparam logic [31:0] RAD_Q40     = 32'd299845282;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // Horner divisors n*(n+1), even n from 12 down to 2
    localparam int unsigned TAYLOR_TERMS = 6;
    localparam logic [7:0] TAYLOR_DIV [TAYLOR_TERMS] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    // reciprocals floor(2^s / d) with s = 32 + floor(log2 d); the estimate
    // (a * recip) >> s of a 32-bit a is low by at most one
    localparam logic [31:0] TAYLOR_RECIP [TAYLOR_TERMS] =
        '{32'd3524075730, 32'd2498890063, 32'd3817748707,
          32'd3272356035, 32'd3435973836, 32'd2863311530};
    localparam logic [5:0] TAYLOR_SHIFT [TAYLOR_TERMS] =
        '{6'd39, 6'd38, 6'd38, 6'd37, 6'd36, 6'd34};

    // two subtract steps per cycle over shifts 17 down to 0
    localparam int unsigned WRAP_GROUPS = 9;

    // divider: 40-bit dividend, 8-bit divisor, 4 bits per cycle
    localparam int unsigned DIV_W      = 40;
    localparam int unsigned DIV_RADIX  = 4;
    localparam int unsigned DIV_CYCLES = DIV_W / DIV_RADIX;

    // configuration register indexes
    localparam logic [2:0] CFG_ROTATION = 3'd0;
    localparam logic [2:0] CFG_SCALE    = 3'd1;
    localparam logic [2:0] CFG_CENTER_X = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y = 3'd3;
    localparam logic [2:0] CFG_LIMIT    = 3'd4;

    localparam logic [1:0]  RST_ROTATION = 2'd3;
    localparam logic [3:0]  RST_SCALE    = 4'd5;
    localparam logic [9:0]  RST_CENTER_X = 10'd160;
    localparam logic [9:0]  RST_CENTER_Y = 10'd120;
    localparam logic [10:0] RST_LIMIT    = 11'd720;

    typedef struct packed {
        logic [14:0] start_angle;
        logic [14:0] end_angle;
        logic [7:0]  sample_count;
        logic [7:0]  sample_index;
        logic [13:0] range_mm;
    } t_item;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               erase;
        logic               last;
    } t_result;

    // classified item as queued between front and back
    typedef struct packed {
        logic [14:0] start_angle;
        logic [31:0] span;
        logic [7:0]  sample_count;
        logic [7:0]  sample_index;
        logic [13:0] range_mm;
        logic        draw;
    } t_work;

    typedef struct packed {
        logic [1:0]  rotation_steps;
        logic [3:0]  scale_shift;
        logic [9:0]  center_x;
        logic [9:0]  center_y;
        logic [10:0] history_limit;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [7:0]       divisor;
    } t_div_req;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERASE,
        ST_OFF_MUL,
        ST_OFF_DIV,
        ST_OFF_WAIT,
        ST_ANGLE,
        ST_WRAP,
        ST_QUAD,
        ST_X_MUL,
        ST_X2_MUL,
        ST_TERM_INIT,
        ST_TERM_MUL,
        ST_TERM_RECIP,
        ST_TERM_EST,
        ST_TERM_FIX,
        ST_FIN_MUL,
        ST_FIN_ROUND,
        ST_PX_MUL,
        ST_PX,
        ST_PY_MUL,
        ST_PY,
        ST_PUSH
    } t_bstate;

endpackage

`default_nettype wire

// ----- sv/lsp_ram.sv -----
// ----------------------------------------------------------------------------
// lsp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/lsp_fifo.sv -----
// ----------------------------------------------------------------------------
// lsp_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (pop_ok) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lsp_div.sv -----
// ----------------------------------------------------------------------------
// lsp_div
// Restoring divider, 40-bit dividend by 8-bit divisor, radix 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_div
    import lsp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    output logic                  o_busy,
    output logic                  o_done,
    output logic      [DIV_W-1:0] o_quot
);

    localparam int unsigned KW = $clog2(DIV_CYCLES + 1);

    logic [DIV_W-1:0] r_q, n_q;
    logic [7:0]       r_rem, n_rem;
    logic [7:0]       r_div;
    logic [KW-1:0]    r_cnt;
    logic             r_done;

    always_comb begin
        logic [8:0] t9;
        n_q   = r_q;
        n_rem = r_rem;
        for (int i = 0; i < DIV_RADIX; i++) begin
            t9  = {n_rem, n_q[DIV_W-1]};
            n_q = {n_q[DIV_W-2:0], 1'b0};
            if (t9 >= {1'b0, r_div}) begin
                t9     = t9 - {1'b0, r_div};
                n_q[0] = 1'b1;
            end
            n_rem = t9[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= KW'(DIV_CYCLES);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - KW'(1);
            r_done <= (r_cnt == KW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ----- sv/lsp_front.sv -----
// ----------------------------------------------------------------------------
// lsp_front
// Accept samples, work out the packet span and the draw flag, queue them.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_front
    import lsp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_take,
    output logic       o_avail,
    output t_work      o_work
);

    t_work work;
    logic  empty;

    always_comb begin
        work.start_angle  = i_item.start_angle;
        work.sample_count = i_item.sample_count;
        work.sample_index = i_item.sample_index;
        work.range_mm     = i_item.range_mm;
        work.draw         = (i_item.range_mm != '0);
        // wrap through a full turn when the packet crosses zero
        if (i_item.start_angle > i_item.end_angle) begin
            work.span = 32'(i_item.end_angle) + 32'(ANG_FULL) - 32'(i_item.start_angle);
        end else begin
            work.span = 32'(i_item.end_angle) - 32'(i_item.start_angle);
        end
    end

    lsp_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (LSP_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (work),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_rdata (o_work),
        .o_empty (empty)
    );

    assign o_avail = ~empty;

endmodule

`default_nettype wire

// ----- sv/lsp_back.sv -----
// ----------------------------------------------------------------------------
// lsp_back
// Sequencer: erase from history, angle, sine/cosine, pixel placement.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_back
    import lsp_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = LSP_HISTORY_DEPTH,
    parameter int unsigned TRIG_BITS     = LSP_TRIG_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_avail,
    input  wire t_work i_work,
    output logic       o_take,
    input  wire logic  i_pop,
    output t_result    o_result,
    output logic       o_empty
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned MW = TRIG_BITS + 1;
    localparam logic [32:0] RND = 33'(1) << (29 - TRIG_BITS);

    t_bstate     r_state, n_state;
    t_work       r_it, n_it;
    logic [31:0] r_acc, n_acc;
    logic [3:0]  r_mg, n_mg;
    logic [1:0]  r_quad, n_quad;
    logic [12:0] r_r, n_r, r_arg, n_arg;
    logic        r_phase, n_phase;
    logic [30:0] r_x, n_x, r_t, n_t;
    logic [31:0] r_x2, n_x2;
    logic [31:0] r_num, n_num;
    logic [30:0] r_quo, n_quo;
    logic [2:0]  r_term, n_term;
    logic [MW-1:0] r_sr, n_sr, r_sc, n_sc;
    logic [15:0] r_px, n_px, r_py, n_py;
    logic [63:0] r_prod, n_prod;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    t_div_req    div_req;
    logic        div_busy, div_done;
    logic [DIV_W-1:0] div_quot;
    logic        ram_we;
    logic [31:0] ram_rdata;
    logic        out_push, out_full;
    t_result     out_data;
    logic [MW-1:0] mag_x, mag_y;
    logic [5:0]  shift_k;

    function automatic logic [15:0] f_place(logic [63:0] p, logic [9:0] centre,
                                            logic neg, logic [5:0] k);
        logic [63:0] q;
        logic [63:0] mask;
        logic        rnz;
        logic [15:0] v;
        q    = p >> k;
        mask = (64'd1 << k) - 64'd1;
        rnz  = |(p & mask);
        // negative side rounds toward minus infinity
        v    = neg ? (16'd0 - (q[15:0] + 16'(rnz))) : q[15:0];
        return v + 16'(centre);
    endfunction

    assign shift_k = 6'(TRIG_BITS) + 6'(i_cfg.scale_shift);
    assign mag_x   = r_quad[0] ? r_sr : r_sc;
    assign mag_y   = r_quad[0] ? r_sc : r_sr;

    // one shared multiplier, always registered into r_prod
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_OFF_MUL: begin
                mul_a = r_it.span;
                mul_b = 32'(r_it.sample_index);
            end
            ST_X_MUL: begin
                mul_a = 32'(r_arg);
                mul_b = RAD_Q40;
            end
            ST_X2_MUL: begin
                mul_a = 32'(r_prod[40:10]);
                mul_b = 32'(r_prod[40:10]);
            end
            ST_TERM_MUL: begin
                mul_a = r_x2;
                mul_b = 32'(r_t);
            end
            ST_TERM_RECIP: begin
                mul_a = r_prod[61:30];
                mul_b = TAYLOR_RECIP[r_term];
            end
            ST_FIN_MUL: begin
                mul_a = 32'(r_x);
                mul_b = 32'(r_t);
            end
            ST_PX_MUL: begin
                mul_a = 32'(r_it.range_mm);
                mul_b = 32'(mag_x);
            end
            ST_PY_MUL: begin
                mul_a = 32'(r_it.range_mm);
                mul_b = 32'(mag_y);
            end
            default: begin
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        logic [31:0] lim;
        logic [31:0] tmp;
        logic [31:0] sub;
        logic [14:0] ang;
        logic [32:0] rnd;
        logic [31:0] qd;
        logic [31:0] rem;
        n_state  = r_state;
        n_it     = r_it;
        n_acc    = r_acc;
        n_mg     = r_mg;
        n_quad   = r_quad;
        n_r      = r_r;
        n_arg    = r_arg;
        n_phase  = r_phase;
        n_x      = r_x;
        n_t      = r_t;
        n_x2     = r_x2;
        n_num    = r_num;
        n_quo    = r_quo;
        n_term   = r_term;
        n_sr     = r_sr;
        n_sc     = r_sc;
        n_px     = r_px;
        n_py     = r_py;
        n_prod   = r_prod;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        o_take   = 1'b0;
        div_req  = '0;
        ram_we   = 1'b0;
        out_push = 1'b0;
        out_data = '0;

        lim = 32'(i_cfg.history_limit);
        if (lim == 32'd0) begin
            lim = 32'd1;
        end
        if (lim > 32'(HISTORY_DEPTH)) begin
            lim = 32'(HISTORY_DEPTH);
        end
        tmp = r_acc;
        sub = '0;
        ang = r_acc[14:0];
        rnd = {1'b0, r_prod[61:30]} + RND;
        qd  = 32'(r_quo) * 32'(TAYLOR_DIV[r_term]);
        rem = r_num - qd;

        case (r_state)
            ST_IDLE: begin
                if (i_avail) begin
                    o_take = 1'b1;
                    n_it   = i_work;
                    if (r_cnt != '0 && 32'(r_cnt) >= lim) begin
                        n_state = ST_ERASE;
                    end else if (i_work.draw) begin
                        n_state = ST_OFF_MUL;
                    end
                end
            end
            ST_ERASE: begin
                if (!out_full) begin
                    out_push         = 1'b1;
                    out_data.pixel_x = ram_rdata[15:0];
                    out_data.pixel_y = ram_rdata[31:16];
                    out_data.erase   = 1'b1;
                    out_data.last    = ~r_it.draw;
                    n_tail  = (r_tail == AW'(HISTORY_DEPTH - 1)) ? '0 : r_tail + AW'(1);
                    n_cnt   = r_cnt - CW'(1);
                    n_state = r_it.draw ? ST_OFF_MUL : ST_IDLE;
                end
            end
            ST_OFF_MUL: begin
                n_prod  = mul_p;
                n_state = ST_OFF_DIV;
            end
            ST_OFF_DIV: begin
                if (r_it.sample_count == '0) begin
                    n_acc   = '0;
                    n_state = ST_ANGLE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_prod[DIV_W-1:0];
                    div_req.divisor  = r_it.sample_count;
                    n_state          = ST_OFF_WAIT;
                end
            end
            ST_OFF_WAIT: begin
                if (div_done) begin
                    n_acc   = div_quot[31:0];
                    n_state = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                n_acc = 32'(r_it.start_angle) + r_acc
                      + 32'(ANG_QUARTER) * 32'(i_cfg.rotation_steps);
                n_mg    = 4'(WRAP_GROUPS - 1);
                n_state = ST_WRAP;
            end
            ST_WRAP: begin
                // reduce modulo a full turn, two shifted subtracts per cycle
                sub = 32'(ANG_FULL) << {r_mg, 1'b1};
                if (tmp >= sub) begin
                    tmp = tmp - sub;
                end
                sub = 32'(ANG_FULL) << {r_mg, 1'b0};
                if (tmp >= sub) begin
                    tmp = tmp - sub;
                end
                n_acc = tmp;
                if (r_mg == '0) begin
                    n_state = ST_QUAD;
                end else begin
                    n_mg = r_mg - 4'd1;
                end
            end
            ST_QUAD: begin
                if (ang >= 15'(3 * ANG_QUARTER)) begin
                    n_quad = 2'd3;
                    n_r    = 13'(ang - 15'(3 * ANG_QUARTER));
                end else if (ang >= 15'(2 * ANG_QUARTER)) begin
                    n_quad = 2'd2;
                    n_r    = 13'(ang - 15'(2 * ANG_QUARTER));
                end else if (ang >= 15'(ANG_QUARTER)) begin
                    n_quad = 2'd1;
                    n_r    = 13'(ang - 15'(ANG_QUARTER));
                end else begin
                    n_quad = 2'd0;
                    n_r    = 13'(ang);
                end
                n_arg   = n_r;
                n_phase = 1'b0;
                n_state = ST_X_MUL;
            end
            ST_X_MUL: begin
                n_prod  = mul_p;
                n_state = ST_X2_MUL;
            end
            ST_X2_MUL: begin
                n_x     = r_prod[40:10];
                n_prod  = mul_p;
                n_state = ST_TERM_INIT;
            end
            ST_TERM_INIT: begin
                n_x2    = r_prod[61:30];
                n_t     = Q30_ONE;
                n_term  = '0;
                n_state = ST_TERM_MUL;
            end
            ST_TERM_MUL: begin
                n_prod  = mul_p;
                n_state = ST_TERM_RECIP;
            end
            ST_TERM_RECIP: begin
                // divide by the Horner constant through its reciprocal
                n_num   = r_prod[61:30];
                n_prod  = mul_p;
                n_state = ST_TERM_EST;
            end
            ST_TERM_EST: begin
                n_quo   = 31'(r_prod >> TAYLOR_SHIFT[r_term]);
                n_state = ST_TERM_FIX;
            end
            ST_TERM_FIX: begin
                // estimate may be one short; bump it when the remainder allows
                n_t = Q30_ONE - (r_quo + 31'(rem >= 32'(TAYLOR_DIV[r_term])));
                if (r_term == 3'(TAYLOR_TERMS - 1)) begin
                    n_state = ST_FIN_MUL;
                end else begin
                    n_term  = r_term + 3'd1;
                    n_state = ST_TERM_MUL;
                end
            end
            ST_FIN_MUL: begin
                n_prod  = mul_p;
                n_state = ST_FIN_ROUND;
            end
            ST_FIN_ROUND: begin
                if (!r_phase) begin
                    n_sr    = MW'(rnd >> (30 - TRIG_BITS));
                    n_phase = 1'b1;
                    n_arg   = 13'(ANG_QUARTER) - r_r;
                    n_state = ST_X_MUL;
                end else begin
                    n_sc    = MW'(rnd >> (30 - TRIG_BITS));
                    n_state = ST_PX_MUL;
                end
            end
            ST_PX_MUL: begin
                n_prod  = mul_p;
                n_state = ST_PX;
            end
            ST_PX: begin
                n_px    = f_place(r_prod, i_cfg.center_x, r_quad[0] ^ r_quad[1], shift_k);
                n_state = ST_PY_MUL;
            end
            ST_PY_MUL: begin
                n_prod  = mul_p;
                n_state = ST_PY;
            end
            ST_PY: begin
                n_py    = f_place(r_prod, i_cfg.center_y, r_quad[1], shift_k);
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (!out_full) begin
                    out_push         = 1'b1;
                    out_data.pixel_x = r_px;
                    out_data.pixel_y = r_py;
                    out_data.erase   = 1'b0;
                    out_data.last    = 1'b1;
                    ram_we  = 1'b1;
                    n_head  = (r_head == AW'(HISTORY_DEPTH - 1)) ? '0 : r_head + AW'(1);
                    n_cnt   = r_cnt + CW'(1);
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it    <= n_it;
        r_acc   <= n_acc;
        r_mg    <= n_mg;
        r_quad  <= n_quad;
        r_r     <= n_r;
        r_arg   <= n_arg;
        r_phase <= n_phase;
        r_x     <= n_x;
        r_t     <= n_t;
        r_x2    <= n_x2;
        r_num   <= n_num;
        r_quo   <= n_quo;
        r_term  <= n_term;
        r_sr    <= n_sr;
        r_sc    <= n_sc;
        r_px    <= n_px;
        r_py    <= n_py;
        r_prod  <= n_prod;
    end

    lsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    lsp_ram #(
        .WIDTH (32),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata ({r_py, r_px}),
        .i_raddr (r_tail),
        .o_rdata (ram_rdata)
    );

    lsp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (LSP_QUEUE_DEPTH)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_data),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_rdata (o_result),
        .o_empty (o_empty)
    );

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(HISTORY_DEPTH))
        else $error("history fill beyond ring depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_head == r_tail))
        else $error("empty ring with unequal pointers");

    a_erase_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ERASE) |-> (r_cnt != '0))
        else $error("erase from an empty ring");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire

// ----- sv/lidar_scan_point_plotter.sv -----
// ----------------------------------------------------------------------------
// lidar_scan_point_plotter
// Lidar samples in, screen draw and erase points out, with a history ring.
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer when            payload
//  --------  ---------  -----------------------  --------------------------
//  sample    in         push & !full             i_item (t_item)
//  point     out        pop & !empty             o_result (t_result)
//  config    in         i_cfg_valid & ready      i_cfg_index, i_cfg_data
//
//  A sample with no return and nothing to erase is only taken by the back
//  end; an erase adds the erase state. A drawn sample waits on the offset
//  divider (not used with a zero sample count), then runs the angle wrap
//  and the two sines, whose six Taylor divisions by constants are
//  reciprocal multiplies.
//  Reset clears config to defaults and empties the ring; no clearing pass.
//  The front queue keeps accepting, until it is full, while the back end
//  works or waits on a full point queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_scan_point_plotter
    import lsp_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = LSP_HISTORY_DEPTH,
    parameter int unsigned TRIG_BITS     = LSP_TRIG_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    input  wire t_item       i_item,
    output logic             full,
    input  wire logic        pop,
    output t_result          o_result,
    output logic             empty,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  take, avail;
    t_work work;

    // config is always taken; write it only while nothing is in flight
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation_steps <= RST_ROTATION;
            r_cfg.scale_shift    <= RST_SCALE;
            r_cfg.center_x       <= RST_CENTER_X;
            r_cfg.center_y       <= RST_CENTER_Y;
            r_cfg.history_limit  <= RST_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROTATION: r_cfg.rotation_steps <= i_cfg_data[1:0];
                CFG_SCALE:    r_cfg.scale_shift    <= i_cfg_data[3:0];
                CFG_CENTER_X: r_cfg.center_x       <= i_cfg_data[9:0];
                CFG_CENTER_Y: r_cfg.center_y       <= i_cfg_data[9:0];
                CFG_LIMIT:    r_cfg.history_limit  <= i_cfg_data;
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // classify and queue samples
    lsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_take  (take),
        .o_avail (avail),
        .o_work  (work)
    );

    // erase, trig and placement
    lsp_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TRIG_BITS     (TRIG_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_avail  (avail),
        .i_work   (work),
        .o_take   (take),
        .i_pop    (pop),
        .o_result (o_result),
        .o_empty  (empty)
    );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar scan point plotter.
// ----------------------------------------------------------------------------
//
//  Samples go in through the push/full queue. Each accepted sample runs
//  through a bit-exact copy of the angle, sine and history ring arithmetic.
//  That copy queues the erase and draw points the block should emit. The
//  checker pops results with random stalls and compares each one, field by
//  field, against the oldest queued point.
//
//  Run order: directed corner samples, then a history limit walk, then four
//  random phases. Each random phase sets its own rotation, scale and centre,
//  sets the limit, and uses its own mix of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import lsp_pkg::*;

    localparam int unsigned FULL_TURN    = 23040;
    localparam int unsigned QUARTER_TURN = 5760;
    localparam int unsigned RING_DEPTH   = 1024;
    localparam int unsigned FRAC_BITS    = 16;
    localparam int unsigned SETTLE_CYCLES = 600;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    t_item       i_item;
    logic        full;
    logic        pop;
    t_result     o_result;
    logic        empty;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [10:0] i_cfg_data;

    lidar_scan_point_plotter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .pop         (pop),
        .o_result    (o_result),
        .empty       (empty),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // mirror of the block's settings and history ring
    logic [1:0]  rot_steps;
    logic [3:0]  shift_bits;
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [10:0] keep_limit;
    logic [31:0] trail [$];     // drawn points, oldest first: y high, x low

    t_result     pending_points [$];
    int          error_count;
    int          samples_sent;
    int          points_checked;
    int          erases_checked;
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned cycle_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Arithmetic copy
    // ------------------------------------------------------------------

    // sine of r within a quarter turn, FRAC_BITS fraction bits
    function automatic longint unsigned quarter_sin(int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned one;
        int              n;
        one = 64'd1 << 30;
        x   = (64'(r) * 64'd299845282) >> 10;
        x2  = (x * x) >> 30;
        t   = one;
        for (n = 12; n >= 2; n -= 2) begin
            t = one - ((x2 * t) >> 30) / 64'(n * (n + 1));
        end
        t = (x * t) >> 30;
        return (t + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    // centre + floor(range * (+/-mag) / 2^k), truncated to 16 bits
    function automatic logic [15:0] screen_coord(logic [9:0] centre,
                                                 logic [13:0] range,
                                                 longint unsigned mag,
                                                 bit neg);
        int unsigned     k;
        longint unsigned p;
        longint          v;
        k = FRAC_BITS + shift_bits;
        p = 64'(range) * mag;
        if (neg) begin
            v = -longint'((p + ((64'd1 << k) - 64'd1)) >> k);
        end else begin
            v = longint'(p >> k);
        end
        v = v + longint'(centre);
        return v[15:0];
    endfunction

    // queue the points one accepted sample must produce, update the ring
    task automatic predict_points(t_item it);
        int unsigned     lim;
        logic [31:0]     span;
        logic [31:0]     off;
        logic [31:0]     ang;
        int unsigned     quad;
        int unsigned     rem;
        longint unsigned s_mag;
        longint unsigned c_mag;
        longint unsigned mx;
        longint unsigned my;
        bit              nx;
        bit              ny;
        t_result         pt;
        logic [31:0]     old;
        int              first;

        first = pending_points.size();
        lim = keep_limit;
        if (lim == 0) lim = 1;
        if (lim > RING_DEPTH) lim = RING_DEPTH;

        if (trail.size() > 0 && trail.size() >= lim) begin
            old = trail.pop_front();
            pt.pixel_x = old[15:0];
            pt.pixel_y = old[31:16];
            pt.erase   = 1'b1;
            pt.last    = 1'b0;
            pending_points.push_back(pt);
        end

        if (it.range_mm != '0) begin
            // 32-bit wrap on purpose: starts beyond a full turn go negative
            span = 32'(it.end_angle) - 32'(it.start_angle);
            if (it.start_angle > it.end_angle) begin
                span = 32'(it.end_angle) + FULL_TURN - 32'(it.start_angle);
            end
            off = '0;
            if (it.sample_count != '0) begin
                off = 32'((64'(span) * 64'(it.sample_index)) / 64'(it.sample_count));
            end
            ang  = (32'(it.start_angle) + off + QUARTER_TURN * rot_steps) % FULL_TURN;
            quad = ang / QUARTER_TURN;
            rem  = ang % QUARTER_TURN;
            s_mag = quarter_sin(rem);
            c_mag = quarter_sin(QUARTER_TURN - rem);
            case (quad)
                0: begin mx = c_mag; nx = 0; my = s_mag; ny = 0; end
                1: begin mx = s_mag; nx = 1; my = c_mag; ny = 0; end
                2: begin mx = c_mag; nx = 1; my = s_mag; ny = 1; end
                default: begin mx = s_mag; nx = 0; my = c_mag; ny = 1; end
            endcase
            pt.pixel_x = screen_coord(origin_x, it.range_mm, mx, nx);
            pt.pixel_y = screen_coord(origin_y, it.range_mm, my, ny);
            pt.erase   = 1'b0;
            pt.last    = 1'b0;
            pending_points.push_back(pt);
            trail.push_back({pt.pixel_y, pt.pixel_x});
        end

        // flag the final point of this sample
        if (pending_points.size() > first) begin
            pending_points[pending_points.size() - 1].last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Point checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_pt;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_points.size() == 0) begin
                    $error("unexpected point x=%0d y=%0d erase=%0b",
                           o_result.pixel_x, o_result.pixel_y, o_result.erase);
                    error_count++;
                end else begin
                    exp_pt = pending_points.pop_front();
                    points_checked++;
                    if (exp_pt.erase) erases_checked++;
                    if (o_result.pixel_x !== exp_pt.pixel_x) begin
                        $error("pixel_x: expected %0d, got %0d",
                               exp_pt.pixel_x, o_result.pixel_x);
                        error_count++;
                    end
                    if (o_result.pixel_y !== exp_pt.pixel_y) begin
                        $error("pixel_y: expected %0d, got %0d",
                               exp_pt.pixel_y, o_result.pixel_y);
                        error_count++;
                    end
                    if (o_result.erase !== exp_pt.erase) begin
                        $error("erase: expected %0b, got %0b",
                               exp_pt.erase, o_result.erase);
                        error_count++;
                    end
                    if (o_result.last !== exp_pt.last) begin
                        $error("last: expected %0b, got %0b",
                               exp_pt.last, o_result.last);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points outstanding",
                     cycle_count, pending_points.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // transfer one sample; push stays high for a back-to-back follower
    task automatic send_sample(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        predict_points(it);
        samples_sent++;
    endtask

    // hold off until every point has drained and the back end is quiet
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [10:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ROTATION: rot_steps  = val[1:0];
            CFG_SCALE:    shift_bits = val[3:0];
            CFG_CENTER_X: origin_x   = val[9:0];
            CFG_CENTER_Y: origin_y   = val[9:0];
            CFG_LIMIT:    keep_limit = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [1:0] rot, logic [3:0] sh, logic [9:0] cx,
                             logic [9:0] cy, logic [10:0] lim);
        write_reg(CFG_ROTATION, 11'(rot));
        write_reg(CFG_SCALE, 11'(sh));
        write_reg(CFG_CENTER_X, 11'(cx));
        write_reg(CFG_CENTER_Y, 11'(cy));
        write_reg(CFG_LIMIT, lim);
    endtask

    function automatic t_item make_sample(logic [14:0] s, logic [14:0] e,
                                          logic [7:0] c, logic [7:0] i,
                                          logic [13:0] r);
        t_item it;
        it.start_angle  = s;
        it.end_angle    = e;
        it.sample_count = c;
        it.sample_index = i;
        it.range_mm     = r;
        return it;
    endfunction

    // mostly well-formed packets, some full-width noise, some broken ones
    function automatic t_item random_sample();
        t_item it;
        int    kind;
        kind = $urandom_range(99);
        it.start_angle  = 15'($urandom_range(FULL_TURN - 1));
        it.end_angle    = 15'($urandom_range(FULL_TURN - 1));
        it.sample_count = 8'($urandom_range(255, 1));
        it.sample_index = 8'($urandom_range(it.sample_count - 1));
        it.range_mm     = ($urandom_range(99) < 95) ? 14'($urandom_range(16383, 1)) : '0;
        if (kind >= 90) begin
            it = t_item'($urandom());
            it.start_angle = 15'($urandom());
        end else if (kind >= 80) begin
            if ($urandom_range(1)) it.sample_count = '0;
            else it.sample_index = 8'($urandom_range(255, it.sample_count));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // corner samples at reset settings
    task automatic test_directed();
        send_sample(make_sample(15'd0, 15'd0, 8'd1, 8'd0, 14'd0));   // empty ring, no return
        send_sample(make_sample(15'd0, 15'd0, 8'd1, 8'd0, 14'd16383));
        send_sample(make_sample(15'd23039, 15'd0, 8'd255, 8'd254, 14'd1)); // wraps the turn
        send_sample(make_sample(15'd100, 15'd9000, 8'd0, 8'd200, 14'd1000)); // zero count
        send_sample(make_sample(15'd100, 15'd9000, 8'd10, 8'd255, 14'd5000)); // index past count
        send_sample(make_sample(15'h7FFF, 15'h7FFF, 8'hFF, 8'hFF, 14'h3FFF));
        send_sample(make_sample(15'h7FFF, 15'd0, 8'd7, 8'd3, 14'd100)); // start past a turn
        send_sample(make_sample(15'd5760, 15'd5760, 8'd1, 8'd0, 14'd2000));
        send_sample(make_sample(15'd11520, 15'd11520, 8'd1, 8'd0, 14'd2000));
        send_sample(make_sample(15'd17280, 15'd17280, 8'd1, 8'd0, 14'd2000));
        send_sample(make_sample(15'd5759, 15'd5759, 8'd1, 8'd0, 14'd2000));
        send_sample(make_sample(15'd22000, 15'd1000, 8'd200, 8'd199, 14'd8191));
        wait_idle();
    endtask

    // lower the limit below the fill, then to zero
    task automatic test_history_limit();
        write_reg(CFG_LIMIT, 11'd2);
        send_sample(make_sample(15'd0, 15'd23039, 8'd8, 8'd1, 14'd3000));
        send_sample(make_sample(15'd0, 15'd23039, 8'd8, 8'd2, 14'd0)); // erase only
        send_sample(make_sample(15'd0, 15'd23039, 8'd8, 8'd3, 14'd0));
        send_sample(make_sample(15'd0, 15'd23039, 8'd8, 8'd4, 14'd0));
        wait_idle();
        write_reg(CFG_LIMIT, 11'd0);    // behaves as one
        send_sample(make_sample(15'd300, 15'd600, 8'd4, 8'd1, 14'd700));
        send_sample(make_sample(15'd300, 15'd600, 8'd4, 8'd2, 14'd700));
        send_sample(make_sample(15'd300, 15'd600, 8'd4, 8'd3, 14'd0));
        send_sample(make_sample(15'd300, 15'd600, 8'd4, 8'd3, 14'd0)); // erase only again
        wait_idle();
    endtask

    task automatic test_random_phase(int n, int sidle, int rstall);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        repeat (n) send_sample(random_sample());
        wait_idle();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_item         = '0;
        pop            = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_ROTATION;
        i_cfg_data     = '0;
        error_count    = 0;
        samples_sent   = 0;
        points_checked = 0;
        erases_checked = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_count    = 0;
        rot_steps      = RST_ROTATION;
        shift_bits     = RST_SCALE;
        origin_x       = RST_CENTER_X;
        origin_y       = RST_CENTER_Y;
        keep_limit     = RST_LIMIT;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_history_limit();
        // limit above the ring depth clamps to it
        write_all(2'd0, 4'd0, 10'd0, 10'd1023, 11'd2047);
        test_random_phase(400, 0, 0);
        write_all(2'd1, 4'd15, 10'd1023, 10'd0, 11'd1024);
        test_random_phase(400, 59, 0);
        write_all(2'd2, 4'd7, 10'd512, 10'd300, 11'd1024);
        test_random_phase(300, 0, 59);
        // shrink the history well below the fill
        write_all(2'd3, 4'd3, 10'd160, 10'd120, 11'd5);
        test_random_phase(150, 31, 31);

        $display("covered %0d samples, %0d points checked (%0d erases)",
                 samples_sent, points_checked, erases_checked);
        $display("all rotations, scale and centre extremes, limits 0 to 2047");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/lsp_pkg.sv
sv/lsp_ram.sv
sv/lsp_fifo.sv
sv/lsp_div.sv
sv/lsp_front.sv
sv/lsp_back.sv
sv/lidar_scan_point_plotter.sv
test/tb_top.sv
